/* src/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted min priority queue package
// Shared beat types, control struct and codes for the queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W     = 32;
    localparam int CFG_W       = 5;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] push_value;
    } req_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      is_empty;
        logic [STATUS_W-1:0]       status;
    } rsp_beat_t;

    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic signed [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

/* src/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted min priority queue cell
// Holds one entry, compares it with the pushed value and shifts with its
// neighbors on push or pop.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                              clk,
    input  spq_pkg::cell_ctl_t                ctl,
    input  logic                              valid,
    input  logic                              prev_gt,
    input  logic signed [spq_pkg::VALUE_W-1:0] prev_data,
    input  logic signed [spq_pkg::VALUE_W-1:0] succ_data,
    output logic                              gt,
    output logic signed [spq_pkg::VALUE_W-1:0] data,
    output logic signed [spq_pkg::VALUE_W-1:0] data_next
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] data_reg;

    assign gt   = valid && (data_reg > ctl.value);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.push)
        begin
            if (prev_gt)
            begin
                data_next = prev_data;
            end
            else if (gt || !valid)
            begin
                data_next = ctl.value;
            end
        end
        else if (ctl.pop)
        begin
            data_next = succ_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

/* src/sorted_min_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Result: the result beat is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the result side does not stall; the row of cells
// updates all entries in the cycle of acceptance.
// Reset: entry count cleared, capacity limit set to 16, result register empty; the entry
// cells are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
// Sorted min priority queue unit
// Chain of cells kept in ascending order so the minimum always sits in cell 0.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  spq_pkg::req_beat_t          req_beat,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output spq_pkg::rsp_beat_t          rsp_beat,
    input  logic                        cfg_wr_en,
    input  logic [spq_pkg::CFG_W-1:0]   cfg_wr_data
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = CNT_W + CFG_W;

    logic [CFG_W-1:0]          limit_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    rsp_beat_t                 rsp_beat_reg;
    rsp_beat_t                 rsp_beat_next;

    logic                      req_acc;
    logic                      is_push;
    logic                      is_pop;
    logic                      full;
    logic                      empty;
    logic [CMP_W-1:0]          count_ext;
    logic [CMP_W-1:0]          limit_ext;
    logic [CMP_W-1:0]          count_out_ext;
    cell_ctl_t                 ctl;

    logic                      cell_valid [DEPTH];
    logic                      cell_gt    [DEPTH];
    logic signed [VALUE_W-1:0] cell_data  [DEPTH];
    logic signed [VALUE_W-1:0] cell_next  [DEPTH];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_acc   = req_valid && !req_stall;
    assign is_push   = req_beat.req_type == REQ_PUSH;
    assign is_pop    = req_beat.req_type == REQ_POP;

    assign count_ext = CMP_W'(count_reg);
    assign limit_ext = CMP_W'(limit_reg);
    assign full      = (count_ext >= limit_ext) || (count_ext >= CMP_W'(DEPTH));
    assign empty     = count_reg == '0;

    assign ctl.push  = req_acc && is_push && !full;
    assign ctl.pop   = req_acc && is_pop && !empty;
    assign ctl.value = req_beat.push_value;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign cell_valid[i] = CNT_W'(i) < count_reg;

            spq_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .valid     (cell_valid[i]),
                .prev_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
                .prev_data (cell_data[(i == 0) ? 0 : i - 1]),
                .succ_data (cell_data[(i == DEPTH - 1) ? i : i + 1]),
                .gt        (cell_gt[i]),
                .data      (cell_data[i]),
                .data_next (cell_next[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_out_ext = CMP_W'(count_next);

    always_comb
    begin
        rsp_beat_next.min_value   = (count_next == '0) ? '0 : cell_next[0];
        rsp_beat_next.entry_count = count_out_ext[COUNT_OUT_W-1:0];
        rsp_beat_next.is_empty    = count_next == '0;
        rsp_beat_next.status      = ST_DONE;
        if (is_push && full)
        begin
            rsp_beat_next.status = ST_FULL;
        end
        else if (is_pop && empty)
        begin
            rsp_beat_next.status = ST_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (req_acc)
            begin
                count_reg <= count_next;
            end
            if (req_acc)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            rsp_beat_reg <= rsp_beat_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_sorted_head : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_data[0] <= cell_data[(DEPTH > 1) ? 1 : 0]))
        else $error("head cells out of order");

    a_pop_count : assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && is_pop && !empty) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not decrement the count");

    a_full_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && is_push && full) |=> (count_reg == $past(count_reg)))
        else $error("rejected push changed the count");

endmodule

/* test/sorted_min_priority_queue_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted min priority queue unit testbench
// A queue fed driver sends push and pop request beats while a monitor keeps a
// sorted copy of the stored values, predicts each result beat and compares it
// field by field. Capacity changes are made only while the unit is idle, and
// random gaps on the request channel and random stalls on the result channel are applied.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_unit_tb;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_beat_t          req_beat = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rsp_beat_t          rsp_beat;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;

    req_beat_t                   req_backlog[$];
    rsp_beat_t                   expected_answers[$];
    logic signed [VALUE_W-1:0]   held_values[$];
    logic [CFG_W-1:0]            capacity_limit = CAP_RESET;
    int                          mismatch_count = 0;
    int                          req_gap_left = 0;
    int                          stall_left = 0;
    bit                          gaps_on = 1'b1;
    bit                          stalls_on = 1'b1;

    sorted_min_priority_queue_unit #(
        .DEPTH (QUEUE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_beat    (req_beat),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_beat    (rsp_beat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return $urandom;
        else if (roll < 80)
            return $signed($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh7FFF_FFFE;
            3: return 32'sh8000_0001;
            4: return -1;
            default: return 0;
        endcase
    endfunction

    // Applies one request to the sorted copy and returns the beat it should produce.
    function automatic rsp_beat_t answer_request(req_beat_t rq);
        rsp_beat_t ans;
        int        room;
        int        slot;
        ans = '0;
        ans.status = ST_DONE;
        room = (int'(capacity_limit) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(capacity_limit);
        if (rq.req_type == REQ_PUSH)
        begin
            if (held_values.size() >= room)
                ans.status = ST_FULL;
            else
            begin
                slot = 0;
                while (slot < held_values.size() && held_values[slot] < rq.push_value)
                    slot++;
                held_values.insert(slot, rq.push_value);
            end
        end
        else if (held_values.size() == 0)
            ans.status = ST_EMPTY;
        else
            void'(held_values.pop_front());
        ans.min_value   = (held_values.size() != 0) ? held_values[0] : '0;
        ans.entry_count = COUNT_OUT_W'(held_values.size());
        ans.is_empty    = (held_values.size() == 0);
        return ans;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_gap_left <= 0;
        end
        else if (req_valid && req_stall)
            ;
        else if (req_gap_left > 0)
        begin
            req_valid <= 1'b0;
            req_gap_left <= req_gap_left - 1;
        end
        else if (req_backlog.size() != 0)
        begin
            req_beat <= req_backlog.pop_front();
            req_valid <= 1'b1;
            req_gap_left <= gaps_on ? pick_gap() : 0;
        end
        else
            req_valid <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= pick_gap();
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_beat_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                capacity_limit = cfg_wr_data;
            if (req_valid && !req_stall)
                expected_answers.push_back(answer_request(req_beat));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_answers.size() == 0)
                    note_mismatch("unexpected result beat", '0, rsp_beat.min_value);
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp_beat.min_value !== want.min_value)
                        note_mismatch("min_value", want.min_value, rsp_beat.min_value);
                    if (rsp_beat.entry_count !== want.entry_count)
                        note_mismatch("entry_count", 32'(want.entry_count),
                                      32'(rsp_beat.entry_count));
                    if (rsp_beat.is_empty !== want.is_empty)
                        note_mismatch("is_empty", 32'(want.is_empty), 32'(rsp_beat.is_empty));
                    if (rsp_beat.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(rsp_beat.status));
                end
            end
        end
    end

    task automatic queue_req(logic kind, logic signed [VALUE_W-1:0] value);
        req_beat_t rq;
        rq.req_type = kind;
        rq.push_value = value;
        req_backlog.push_back(rq);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || expected_answers.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] cap;
        int               push_pct;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_req(REQ_POP, 32'sh1234_5678);
        queue_req(REQ_PUSH, 32'sh7FFF_FFFF);
        queue_req(REQ_PUSH, 32'sh8000_0000);
        queue_req(REQ_PUSH, 0);
        queue_req(REQ_PUSH, -1);
        queue_req(REQ_PUSH, 0);
        queue_req(REQ_PUSH, 1);
        repeat (7) queue_req(REQ_POP, $urandom);
        wait_idle();

        write_capacity(5'd2);
        queue_req(REQ_PUSH, 5);
        queue_req(REQ_PUSH, 5);
        queue_req(REQ_PUSH, -9);
        queue_req(REQ_POP, 0);
        queue_req(REQ_POP, 0);
        wait_idle();

        write_capacity(5'd0);
        queue_req(REQ_PUSH, 3);
        queue_req(REQ_POP, -1);
        wait_idle();

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 6)
                0: cap = 5'd31;
                1: cap = 5'd16;
                2: cap = 5'd1;
                3: cap = CFG_W'($urandom_range(0, 31));
                4: cap = CFG_W'($urandom_range(17, 30));
                default: cap = 5'd4;
            endcase
            push_pct = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 35 : 55;
            gaps_on = (phase % 4 != 1);
            stalls_on = (phase % 4 != 2);
            write_capacity(cap);
            repeat (150)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    queue_req(REQ_PUSH, pick_value());
                else
                    queue_req(REQ_POP, $urandom);
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_min_priority_queue_unit.sv
test/sorted_min_priority_queue_unit_tb.sv
